// ----- design/msdfg_pkg.sv -----
package msdfg_pkg;

  localparam int NUM_CHANNELS_DEF       = 2;
  localparam int SAMPLES_PER_PERIOD_DEF = 200;
  localparam int SINE_TABLE_DEPTH_DEF   = 1024;

  localparam int MAX_CHANNELS = 2;
  localparam int PHASE_W      = 16;
  localparam int AMP_W        = 14;
  localparam int OFF_W        = 14;
  localparam int SIN_W        = 16;
  localparam int CODE_W       = 16;
  localparam int CMD_W        = 8;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [CMD_W-1:0]  CMD_WRITE  = 8'h10;
  localparam logic [CMD_W-1:0]  CMD_LATCH  = 8'h30;
  localparam logic [CODE_W-1:0] LATCH_CODE = 16'hFFFF;

  localparam int FULL_SCALE_MV = 5000;
  localparam int CODE_SCALE    = 65535;
  // ceil(2^43 / 10000): exact quotient for every dividend below 2^30
  localparam logic [29:0] RECIP_10000 = 30'd879609303;
  localparam int RECIP_SHIFT = 43;

  // register field codes within one channel's group of four
  localparam logic [1:0] REG_STEP  = 2'd0;
  localparam logic [1:0] REG_AMP   = 2'd1;
  localparam logic [1:0] REG_OFF   = 2'd2;
  localparam logic [1:0] REG_START = 2'd3;

  localparam logic [PHASE_W-1:0] STEP_RST  [MAX_CHANNELS] = '{16'd328, 16'd1638};
  localparam logic [AMP_W-1:0]   AMP_RST   [MAX_CHANNELS] = '{14'd4000, 14'd2000};
  localparam logic [OFF_W-1:0]   OFF_RST   [MAX_CHANNELS] = '{14'd0, 14'd1000};
  localparam logic [PHASE_W-1:0] START_RST [MAX_CHANNELS] = '{16'd0, 16'd0};

  localparam real PI = 3.14159265358979323846;

  typedef struct packed {
    logic issue;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
  } dp_status_t;

  // round(32767 * sin(angle)), ties away from zero
  function automatic logic signed [SIN_W-1:0] sine_q15(real angle);
    real x;
    real m;
    int  r;
    x = 32767.0 * $sin(angle);
    m = (x < 0.0) ? -x : x;
    r = $rtoi(m + 0.5);
    if (x < 0.0) r = -r;
    return SIN_W'(r);
  endfunction

endpackage

// ----- design/msdfg_tick_if.sv -----
interface msdfg_tick_if;
  logic valid;
  logic ready;
  logic sample_tick;

  modport source (output valid, output sample_tick, input ready);
  modport sink (input valid, input sample_tick, output ready);
endinterface

// ----- design/msdfg_frame_if.sv -----
interface msdfg_frame_if;
  logic                            valid;
  logic                            ready;
  logic [msdfg_pkg::CMD_W-1:0]     frame_command;
  logic [msdfg_pkg::CODE_W-1:0]    frame_code;
  logic                            last_of_run;

  modport source (output valid, output frame_command, output frame_code,
                  output last_of_run, input ready);
  modport sink (input valid, input frame_command, input frame_code,
                input last_of_run, output ready);
endinterface

// ----- design/msdfg_ctrl.sv -----
module msdfg_ctrl #(
  parameter int NUM_CHANNELS = msdfg_pkg::NUM_CHANNELS_DEF,
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int FR_W = $clog2(NUM_CHANNELS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_tick_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output msdfg_pkg::dp_cmd_t    cmd_o,
  output logic [CH_W-1:0]       issue_ch_o,
  output logic [FR_W-1:0]       frame_sel_o,
  input  msdfg_pkg::dp_status_t status_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [CH_W-1:0] LAST_CH    = CH_W'(NUM_CHANNELS - 1);
  localparam logic [FR_W-1:0] LAST_FRAME = FR_W'(NUM_CHANNELS);

  logic [1:0]      state_q, state_d;
  logic [CH_W-1:0] ch_q, ch_d;
  logic [FR_W-1:0] frame_q, frame_d;

  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    frame_d     = frame_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_tick_i) begin
          state_d = ST_ISSUE;
          ch_d    = '0;
        end
      end
      ST_ISSUE: begin
        cmd_o.issue = 1'b1;
        if (ch_q == LAST_CH) begin
          state_d = ST_WAIT;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      ST_WAIT: begin
        if (!status_i.busy) begin
          state_d = ST_EMIT;
          frame_d = '0;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (frame_q == LAST_FRAME) begin
            cmd_o.advance = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            frame_d = frame_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ch_q    <= '0;
      frame_q <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
      frame_q <= frame_d;
    end
  end

  assign issue_ch_o  = ch_q;
  assign frame_sel_o = frame_q;

endmodule

// ----- design/msdfg_datapath.sv -----
module msdfg_datapath #(
  parameter int NUM_CHANNELS       = msdfg_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLES_PER_PERIOD = msdfg_pkg::SAMPLES_PER_PERIOD_DEF,
  parameter int SINE_TABLE_DEPTH   = msdfg_pkg::SINE_TABLE_DEPTH_DEF,
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int FR_W = $clog2(NUM_CHANNELS + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [msdfg_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [msdfg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  msdfg_pkg::dp_cmd_t                   cmd_i,
  input  logic [CH_W-1:0]                      issue_ch_i,
  input  logic [FR_W-1:0]                      frame_sel_i,
  output msdfg_pkg::dp_status_t                status_o,
  output logic [msdfg_pkg::CMD_W-1:0]          frame_command_o,
  output logic [msdfg_pkg::CODE_W-1:0]         frame_code_o,
  output logic                                 last_of_run_o
);

  localparam int PW   = msdfg_pkg::PHASE_W;
  localparam int AW   = msdfg_pkg::AMP_W;
  localparam int OW   = msdfg_pkg::OFF_W;
  localparam int SW   = msdfg_pkg::SIN_W;
  localparam int CW   = msdfg_pkg::CODE_W;
  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH);
  localparam int SIDX_W = $clog2(SAMPLES_PER_PERIOD);
  localparam int PROD_W = AW + SW + 1;
  localparam int X_W    = 30;
  localparam int P_W    = 2 * X_W;
  localparam real ANG_STEP = 2.0 * msdfg_pkg::PI / real'(SINE_TABLE_DEPTH);
  localparam logic [SIDX_W-1:0] LAST_SAMPLE = SIDX_W'(SAMPLES_PER_PERIOD - 1);
  localparam logic signed [16:0] FS_POS = 17'(msdfg_pkg::FULL_SCALE_MV);
  localparam logic signed [16:0] FS_NEG = -17'(msdfg_pkg::FULL_SCALE_MV);

  logic [PW-1:0] step_q  [NUM_CHANNELS];
  logic [AW-1:0] amp_q   [NUM_CHANNELS];
  logic [OW-1:0] off_q   [NUM_CHANNELS];
  logic [PW-1:0] start_q [NUM_CHANNELS];
  logic [PW-1:0] rel_q   [NUM_CHANNELS];
  logic [CW-1:0] code_q  [NUM_CHANNELS];
  logic [SIDX_W-1:0] sidx_q;
  logic              wrap;

  logic signed [SW-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = msdfg_pkg::sine_q15(real'(g) * ANG_STEP);
  end

  assign wrap = (sidx_q == LAST_SAMPLE);

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    logic wr_sel;
    assign wr_sel = cfg_we_i && (int'(cfg_idx_i[2]) == c);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        step_q[c]  <= msdfg_pkg::STEP_RST[c];
        amp_q[c]   <= msdfg_pkg::AMP_RST[c];
        off_q[c]   <= msdfg_pkg::OFF_RST[c];
        start_q[c] <= msdfg_pkg::START_RST[c];
      end else if (wr_sel) begin
        unique case (cfg_idx_i[1:0])
          msdfg_pkg::REG_STEP:  step_q[c]  <= cfg_data_i[PW-1:0];
          msdfg_pkg::REG_AMP:   amp_q[c]   <= cfg_data_i[AW-1:0];
          msdfg_pkg::REG_OFF:   off_q[c]   <= cfg_data_i[OW-1:0];
          msdfg_pkg::REG_START: start_q[c] <= cfg_data_i[PW-1:0];
          default: ;
        endcase
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rel_q[c] <= '0;
      end else if (cmd_i.advance) begin
        rel_q[c] <= wrap ? '0 : rel_q[c] + step_q[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sidx_q <= '0;
    end else if (cmd_i.advance) begin
      sidx_q <= wrap ? '0 : sidx_q + 1'b1;
    end
  end

  // five-stage pipeline: lookup, multiply, offset/clamp, scale, reciprocal
  logic [4:0]    vld_q;
  logic [CH_W-1:0] ch_q [5];

  logic [PW-1:0]         phase;
  logic signed [SW-1:0]  s1_sin_q;
  logic [AW-1:0]         s1_amp_q;
  logic [OW-1:0]         s1_off_q, s2_off_q;
  logic signed [PROD_W-1:0] s2_prod_q;
  logic signed [16:0]    sum, clamped;
  logic [AW-1:0]         s3_u_q;
  logic [X_W-1:0]        s4_x_q;
  logic [P_W-1:0]        s5_p_q;

  assign phase = start_q[issue_ch_i] + rel_q[issue_ch_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], cmd_i.issue};
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q[0] <= issue_ch_i;
    for (int i = 1; i < 5; i++) ch_q[i] <= ch_q[i-1];
  end

  always_ff @(posedge clk_i) begin
    s1_sin_q <= sine_rom[phase[PW-1 -: ADDR_W]];
    s1_amp_q <= amp_q[issue_ch_i];
    s1_off_q <= off_q[issue_ch_i];
  end

  always_ff @(posedge clk_i) begin
    s2_prod_q <= $signed({1'b0, s1_amp_q}) * s1_sin_q;
    s2_off_q  <= s1_off_q;
  end

  always_comb begin
    sum = 17'(signed'(s2_off_q)) + 17'(signed'(s2_prod_q[PROD_W-2:15]));
    if (sum > FS_POS) begin
      clamped = FS_POS;
    end else if (sum < FS_NEG) begin
      clamped = FS_NEG;
    end else begin
      clamped = sum;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_u_q <= AW'(clamped + FS_POS);
  end

  always_ff @(posedge clk_i) begin
    s4_x_q <= X_W'({{(X_W-AW){1'b0}}, s3_u_q} * X_W'(msdfg_pkg::CODE_SCALE));
  end

  always_ff @(posedge clk_i) begin
    s5_p_q <= {{X_W{1'b0}}, s4_x_q} * {{X_W{1'b0}}, msdfg_pkg::RECIP_10000};
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[4]) begin
      code_q[ch_q[4]] <= s5_p_q[msdfg_pkg::RECIP_SHIFT + CW - 1 -: CW];
    end
  end

  assign status_o.busy = |vld_q;

  always_comb begin
    if (frame_sel_i < FR_W'(NUM_CHANNELS)) begin
      frame_command_o = msdfg_pkg::CMD_WRITE | msdfg_pkg::CMD_W'(frame_sel_i);
      frame_code_o    = code_q[frame_sel_i[CH_W-1:0]];
      last_of_run_o   = 1'b0;
    end else begin
      frame_command_o = msdfg_pkg::CMD_LATCH;
      frame_code_o    = msdfg_pkg::LATCH_CODE;
      last_of_run_o   = 1'b1;
    end
  end

endmodule

// ----- design/multichannel_sine_dac_frame_generator_unit.sv -----
// Operation: a tick transaction is accepted in the idle state; the channels are issued
// one per cycle into a five-stage lookup/multiply/clamp/scale/reciprocal pipeline, and
// the frames follow once the pipeline has drained.
// Throughput: a new tick is taken only after every frame of the last one has been taken;
// frames go out one per cycle while taken: one per channel, then a latch frame.
// Reset: asynchronous active low; registers return to their defaults, phases and index to 0.
module multichannel_sine_dac_frame_generator_unit #(
  parameter int NUM_CHANNELS       = msdfg_pkg::NUM_CHANNELS_DEF,
  parameter int SAMPLES_PER_PERIOD = msdfg_pkg::SAMPLES_PER_PERIOD_DEF,
  parameter int SINE_TABLE_DEPTH   = msdfg_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [msdfg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [msdfg_pkg::CFG_DATA_W-1:0] cfg_data_i,
  msdfg_tick_if.sink                       tick_i,
  msdfg_frame_if.source                    frame_o
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int FR_W = $clog2(NUM_CHANNELS + 1);

  msdfg_pkg::dp_cmd_t    cmd;
  msdfg_pkg::dp_status_t status;
  logic [CH_W-1:0]       issue_ch;
  logic [FR_W-1:0]       frame_sel;

  msdfg_ctrl #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tick_i.valid),
    .in_tick_i   (tick_i.sample_tick),
    .in_ready_o  (tick_i.ready),
    .out_valid_o (frame_o.valid),
    .out_ready_i (frame_o.ready),
    .cmd_o       (cmd),
    .issue_ch_o  (issue_ch),
    .frame_sel_o (frame_sel),
    .status_i    (status)
  );

  msdfg_datapath #(
    .NUM_CHANNELS       (NUM_CHANNELS),
    .SAMPLES_PER_PERIOD (SAMPLES_PER_PERIOD),
    .SINE_TABLE_DEPTH   (SINE_TABLE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd),
    .issue_ch_i      (issue_ch),
    .frame_sel_i     (frame_sel),
    .status_o        (status),
    .frame_command_o (frame_o.frame_command),
    .frame_code_o    (frame_o.frame_code),
    .last_of_run_o   (frame_o.last_of_run)
  );

endmodule
